// ===== design/utf16_to_utf32_decoder_defines.svh =====
// Assertion macros shared by the UTF-16 to UTF-32 decoder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef UTF16_TO_UTF32_DECODER_DEFINES_SVH
`define UTF16_TO_UTF32_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define UTD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("utd assertion failed");

// Condition must never be true outside reset.
`define UTD_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("utd forbidden condition seen");

`else

`define UTD_ASSERT(lbl, clk, rst, prop)
`define UTD_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== design/utd_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-32 decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package utd_pkg;

   // Widths of the fields and counters.
   localparam int UNIT_W   = 16;
   localparam int POINT_W  = 21;
   localparam int CNT_W    = 13;
   localparam int STATUS_W = 3;
   localparam int PAYLD_W  = 10;

   // Capacity after reset and the saturation value of the counters.
   localparam logic [CNT_W-1:0] MAX_LEN = 13'd4096;
   localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

   // Surrogate ranges and the base of the supplementary planes.
   localparam logic [UNIT_W-1:0]  HIGH_FIRST = 16'hD800;
   localparam logic [UNIT_W-1:0]  HIGH_LAST  = 16'hDBFF;
   localparam logic [UNIT_W-1:0]  LOW_FIRST  = 16'hDC00;
   localparam logic [UNIT_W-1:0]  LOW_LAST   = 16'hDFFF;
   localparam logic [POINT_W-1:0] SUPP_BASE  = 21'h10000;

   // Status codes reported on each result.
   localparam logic [STATUS_W-1:0] STATUS_OK             = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_HIGH_HIGH      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_LONE_LOW       = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BMP_AFTER_HIGH = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CAPACITY       = 3'd4;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_BMP,
      KIND_HIGH,
      KIND_LOW
   } unit_kind_type;

   // One classified code unit as it travels from front to back.
   typedef struct packed {
      unit_kind_type     kind;
      logic [UNIT_W-1:0] code_unit;
      logic              last_unit;
   } unit_item_type;

endpackage

// ===== design/utd_front.sv =====
// Front end of the decoder: accepts code units and classifies them.
// Depends on utd_pkg; feeds the queue in front of utd_back.
`timescale 1ns / 1ps

module utd_front import utd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [UNIT_W-1:0] req_code_unit,
   input  logic              req_last_unit,
   output logic              item_valid,
   input  logic              item_ready,
   output unit_item_type     item_data
);

   logic          valid_ff, valid_in;
   unit_item_type item_ff, item_in;
   unit_kind_type kind;

   // Classify the unit by its surrogate range.
   always_comb begin
      if (req_code_unit >= HIGH_FIRST && req_code_unit <= HIGH_LAST) begin
         kind = KIND_HIGH;
      end else if (req_code_unit >= LOW_FIRST && req_code_unit <= LOW_LAST) begin
         kind = KIND_LOW;
      end else begin
         kind = KIND_BMP;
      end
   end

   // The stage takes a new beat when it is empty or its beat moves on.
   assign req_ready = !valid_ff || item_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         item_in  = '{kind: kind, code_unit: req_code_unit, last_unit: req_last_unit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item_data  = item_ff;

endmodule

// ===== design/utd_queue.sv =====
// Short queue of classified units between the front and back of the decoder.
// Depends on utd_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "utf16_to_utf32_decoder_defines.svh"

module utd_queue import utd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  unit_item_type push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output unit_item_type pop_data
);

   unit_item_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    push, pop;

   localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] FULL_CNT  = QCNT_W'(QUEUE_DEPTH);

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slots_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage, written at the write pointer.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   `UTD_ASSERT_NEVER(a_queue_overfill, clock, reset, count_ff > FULL_CNT)
   `UTD_ASSERT(a_queue_grow, clock, reset,
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
   `UTD_ASSERT(a_queue_ptr_gap, clock, reset,
      (count_ff == '0 || count_ff == FULL_CNT) |-> wr_ptr_ff == rd_ptr_ff)

endmodule

// ===== design/utd_back.sv =====
// Back end of the decoder: string state, surrogate pairing, error latch
// and the result register. Depends on utd_pkg and the defines header.
`timescale 1ns / 1ps
`include "utf16_to_utf32_decoder_defines.svh"

module utd_back import utd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [CNT_W-1:0]    capacity,
   input  logic                item_valid,
   output logic                item_ready,
   input  unit_item_type       item_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POINT_W-1:0]  rsp_code_point,
   output logic                rsp_point_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CNT_W-1:0]    rsp_points_so_far,
   output logic                rsp_end_of_string
);

   // String state.
   logic                pending_ff, pending_in;
   logic [PAYLD_W-1:0]  high_ff, high_in;
   logic [CNT_W-1:0]    units_ff, units_in;
   logic [CNT_W-1:0]    points_ff, points_in;
   logic [STATUS_W-1:0] error_ff, error_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POINT_W-1:0]  cp_ff, cp_in;
   logic                pv_ff, pv_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]    so_far_ff, so_far_in;
   logic                eos_ff, eos_in;

   logic                pop;
   logic [CNT_W:0]      count;

   // A beat leaves the queue when the result register is free or draining.
   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign pop        = item_valid && item_ready;
   assign count      = {1'b0, units_ff} + 1'b1;

   // Decode one unit and update the string state.
   always_comb begin
      pending_in = pending_ff;
      high_in    = high_ff;
      units_in   = units_ff;
      points_in  = points_ff;
      error_in   = error_ff;
      cp_in      = '0;
      pv_in      = 1'b0;
      status_in  = status_ff;
      so_far_in  = so_far_ff;
      eos_in     = eos_ff;
      if (pop) begin
         if (units_ff != CNT_MAX) begin
            units_in = count[CNT_W-1:0];
         end
         if (error_ff == STATUS_OK) begin
            if (count > {1'b0, capacity}) begin
               error_in = STATUS_CAPACITY;
            end else begin
               case (item_data.kind)
                  KIND_HIGH: begin
                     if (pending_ff) begin
                        error_in = STATUS_HIGH_HIGH;
                     end else begin
                        pending_in = 1'b1;
                        high_in    = item_data.code_unit[PAYLD_W-1:0];
                     end
                  end
                  KIND_LOW: begin
                     if (!pending_ff) begin
                        error_in = STATUS_LONE_LOW;
                     end else begin
                        pending_in = 1'b0;
                        cp_in      = SUPP_BASE +
                           {1'b0, high_ff, item_data.code_unit[PAYLD_W-1:0]};
                        pv_in      = 1'b1;
                     end
                  end
                  default: begin
                     if (pending_ff) begin
                        error_in = STATUS_BMP_AFTER_HIGH;
                     end else begin
                        cp_in = {{(POINT_W-UNIT_W){1'b0}}, item_data.code_unit};
                        pv_in = 1'b1;
                     end
                  end
               endcase
            end
            if (pv_in && points_ff != CNT_MAX) begin
               points_in = points_ff + 1'b1;
            end
         end
         status_in = error_in;
         so_far_in = points_in;
         eos_in    = item_data.last_unit;
         // The final unit of a string clears everything after its result.
         if (item_data.last_unit) begin
            pending_in = 1'b0;
            high_in    = '0;
            units_in   = '0;
            points_in  = '0;
            error_in   = STATUS_OK;
         end
      end
   end

   // Result valid follows the output handshake.
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         high_ff      <= '0;
         units_ff     <= '0;
         points_ff    <= '0;
         error_ff     <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         high_ff      <= high_in;
         units_ff     <= units_in;
         points_ff    <= points_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads only when a new beat is decoded.
   always_ff @(posedge clock) begin
      if (pop) begin
         cp_ff     <= cp_in;
         pv_ff     <= pv_in;
         status_ff <= status_in;
         so_far_ff <= so_far_in;
         eos_ff    <= eos_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_point    = cp_ff;
   assign rsp_point_valid   = pv_ff;
   assign rsp_status        = status_ff;
   assign rsp_points_so_far = so_far_ff;
   assign rsp_end_of_string = eos_ff;

   `UTD_ASSERT(a_valid_point_no_error, clock, reset,
      (rsp_valid_ff && pv_ff) |-> status_ff == STATUS_OK)
   `UTD_ASSERT(a_invalid_point_zero, clock, reset,
      (rsp_valid_ff && !pv_ff) |-> cp_ff == '0)
   `UTD_ASSERT(a_error_held, clock, reset,
      (error_ff != STATUS_OK && !(pop && item_data.last_unit))
         |=> error_ff == $past(error_ff))
   `UTD_ASSERT_NEVER(a_points_over_units, clock, reset, points_ff > units_ff)

endmodule

// ===== design/utf16_to_utf32_decoder.sv =====
// UTF-16 to UTF-32 stream decoder: top level.
// Depends on utd_pkg, utd_front, utd_queue and utd_back.
//
// Usage:
//   The req_ channel carries one UTF-16 code unit per beat, with
//   req_last_unit set on the final unit of a string. The rsp_ channel returns
//   exactly one result per unit: the code point (when a point completes), the
//   status, the running point count and a copy of the end-of-string flag.
//   The first error of a string is latched and reported until that string ends.
//   csr_write_enable/csr_write_data set the capacity in units per string; write
//   it only while no unit is in flight.
//   An accepted request beat reaches its result through the input stage,
//   the two-entry queue and the result register. Throughput is one unit
//   per cycle while rsp_ready is high, set by the back end's decode.
//   Reset clears all string state and sets the capacity to 4096; no clearing
//   pass is needed. When the receiver stalls, the result register holds, the
//   queue fills, and req_ready drops once the front stage cannot move.
`timescale 1ns / 1ps

module utf16_to_utf32_decoder import utd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [CNT_W-1:0]    csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [UNIT_W-1:0]   req_code_unit,
   input  logic                req_last_unit,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POINT_W-1:0]  rsp_code_point,
   output logic                rsp_point_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CNT_W-1:0]    rsp_points_so_far,
   output logic                rsp_end_of_string
);

   logic [CNT_W-1:0] capacity_ff, capacity_in;
   logic             front_valid, front_ready;
   unit_item_type    front_data;
   logic             back_valid, back_ready;
   unit_item_type    back_data;

   // Capacity register.
   assign capacity_in = csr_write_enable ? csr_write_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= MAX_LEN;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   utd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .item_valid    (front_valid),
      .item_ready    (front_ready),
      .item_data     (front_data)
   );

   utd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_data)
   );

   utd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .capacity          (capacity_ff),
      .item_valid        (back_valid),
      .item_ready        (back_ready),
      .item_data         (back_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_point    (rsp_code_point),
      .rsp_point_valid   (rsp_point_valid),
      .rsp_status        (rsp_status),
      .rsp_points_so_far (rsp_points_so_far),
      .rsp_end_of_string (rsp_end_of_string)
   );

endmodule
